// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ICF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be seen outside reset.
`define ICF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ICF_ASSERT(lbl, prop, msg)
`define ICF_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/icf_pkg.sv -----
// Types and constants of the interpolated comb filter.
package icf_pkg;

  // Parameter defaults
  localparam int DEPTH_DEFAULT        = 512;
  localparam int SAMPLE_WIDTH_DEFAULT = 16;

  // Fixed field widths
  localparam int DLY_W   = 20;  // delay in ms, signed Q8.12
  localparam int GAIN_W  = 16;  // gains, signed Q2.14
  localparam int SPM_W   = 16;  // samples per ms, unsigned Q8.8
  localparam int LL_W    = 10;  // line length register
  localparam int FRAC_W  = 20;  // fraction bits of a delay in samples
  localparam int DPROD_W = DLY_W + SPM_W + 1;  // delay times rate, signed

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_MS = 2'd1;

  localparam logic [LL_W-1:0]  LINE_LENGTH_RESET = 10'd441;
  localparam logic [SPM_W-1:0] SPM_RESET         = 16'd11290;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MULD,
    S_CLIP,
    S_ADDR,
    S_RD0,
    S_RD1,
    S_DIFF,
    S_MULF,
    S_OUT,
    S_MULC,
    S_WR,
    S_WR0
  } icf_state_e;

endpackage

// ----- hw/rtl/icf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module icf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/interpolated_comb_filter.sv -----
// Top level of the interpolated comb filter: sequencer, shared multiplier, delay store.
//
//  channel   direction  handshake                 payload
//  input     in         in_valid_i / in_stall_o   sample_in, delay_ms, gain_direct,
//                                                 gain_feed_in, gain_feedback
//  output    out        out_valid_o / out_stall_i sample_out
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// The input stalls until an item has run through every step, with an extra guard copy at
// index 0 when the write head wraps: five products share the one multiplier.
// The output register lets an item start while a result waits; a stalled result
// holds the sequencer in its output step until it is taken.
// No clearing pass after reset: a head position and a wrapped flag mark written store
// entries, unwritten entries read as zero. A line_length write does the same.
`include "assert_macros.svh"

module interpolated_comb_filter import icf_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEFAULT,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic signed [DLY_W-1:0]        delay_ms_i,
  input  logic signed [GAIN_W-1:0]       gain_direct_i,
  input  logic signed [GAIN_W-1:0]       gain_feed_in_i,
  input  logic signed [GAIN_W-1:0]       gain_feedback_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int AW   = $clog2(DEPTH);
  localparam int OPW  = (SW + 1 > GAIN_W + 5) ? SW + 1 : GAIN_W + 5;  // multiplier operand
  localparam int PW   = 2 * OPW;
  localparam int SUMW = SW + 4;
  localparam int RW   = AW + FRAC_W + 1;

  localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

  // Clamp to the signed sample range
  function automatic logic [SW-1:0] sat_fn(input logic signed [SUMW-1:0] v);
    logic [SW-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[SW-1:0];
    end else begin
      res = v[SW-1:0];
    end
    return res;
  endfunction

  icf_state_e state_q, state_d;

  // configuration registers
  logic [LL_W-1:0]  line_length_q;
  logic [SPM_W-1:0] spm_q;
  logic             cfg_ll_wr;

  // head and fill tracking
  logic [AW-1:0] head_q, head_d;
  logic          wrapped_q, wrapped_d;

  // captured item
  logic signed [SW-1:0]     x_q;
  logic signed [DLY_W-1:0]  dly_q;
  logic signed [GAIN_W-1:0] a_q, b_q, c_q;

  // datapath registers
  logic signed [PW-1:0]     p_q;
  logic [AW+FRAC_W-1:0]     d_q;
  logic                     pres_q;
  logic [AW-1:0]            n_q;
  logic [FRAC_W-1:0]        f_q;
  logic signed [SW+1:0]     ax_q;
  logic signed [SW+15:0]    bx_q;
  logic signed [SW-1:0]     v0_q;
  logic signed [SW:0]       diff_q;
  logic [SW-1:0]            w_q;
  logic [SW-1:0]            sample_out_q;
  logic                     out_valid_q;

  // shared multiplier
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  mul_p;
  logic                  mul_en;

  // delay store port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata, mem_rdata;

  logic          in_xfer, out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ll_wr  = cfg_we_i && (cfg_idx_i == REG_LINE_LENGTH);

  // Ring period G = clamp(line_length, 2, DEPTH) - 1
  logic [31:0]   ll_w, g_w;
  logic [AW-1:0] g;
  always_comb begin
    ll_w = 32'(line_length_q);
    if (ll_w < 32'd2) begin
      g_w = 32'd1;
    end else if (ll_w > 32'(DEPTH)) begin
      g_w = 32'(DEPTH) - 32'd1;
    end else begin
      g_w = ll_w - 32'd1;
    end
  end
  assign g = g_w[AW-1:0];

  // Delay clip: D >= 0 means a delayed term, D capped at G * 2^20
  logic signed [DPROD_W-1:0] d_full, gfix;
  logic [AW+FRAC_W-1:0]      gfix_u;
  assign gfix_u = {g, {FRAC_W{1'b0}}};
  assign gfix   = $signed(DPROD_W'(gfix_u));
  assign d_full = $signed(p_q[DPROD_W-1:0]);

  // Read position R = head - D, wrapped by G
  logic [RW-1:0] r_raw, r_adj;
  always_comb begin
    r_raw = RW'({head_q, {FRAC_W{1'b0}}}) - RW'(d_q);
    r_adj = r_raw[RW-1] ? (r_raw + RW'(gfix_u)) : r_raw;
  end

  // Neighbor index and fill checks; a neighbor past the ring has zero weight
  logic [AW:0]          n1_w;
  logic                 valid0, valid1;
  logic signed [SW-1:0] v1;
  assign n1_w   = {1'b0, n_q} + (AW + 1)'(1);
  assign valid0 = wrapped_q || (n_q < head_q);
  assign valid1 = (n1_w <= {1'b0, g}) && (wrapped_q || (n1_w < {1'b0, head_q}));
  assign v1     = valid1 ? $signed(mem_rdata) : '0;

  // Output sum: floor(a*x / 2^14) + v0 + floor(diff*f / 2^20), the delayed terms only for D >= 0
  logic signed [SW+1:0] frac;
  logic signed [SUMW-1:0] tsum, ysum;
  logic [SW-1:0] y;
  always_comb begin
    frac = $signed(p_q[SW+FRAC_W+1:FRAC_W]);
    tsum = pres_q ? (SUMW'(v0_q) + SUMW'(frac)) : '0;
    ysum = SUMW'(ax_q) + tsum;
    y    = sat_fn(ysum);
  end

  // Stored value: floor((b*x + c*y) / 2^14)
  logic signed [SW+16:0] wsum;
  logic signed [SW+2:0]  wsh;
  logic [SW-1:0]         w;
  always_comb begin
    wsum = (SW + 17)'(bx_q) + (SW + 17)'($signed(p_q[SW+15:0]));
    wsh  = $signed(wsum[SW+16:14]);
    w    = sat_fn(SUMW'(wsh));
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Sequencer: next state, multiplier operands, store access, head update
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    wrapped_d = wrapped_q;
    mul_a     = '0;
    mul_b     = '0;
    mul_en    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = w;
    mem_raddr = n_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_MULD;
      end
      S_MULD: begin
        mul_a   = OPW'(dly_q);
        mul_b   = OPW'($signed({1'b0, spm_q}));
        mul_en  = 1'b1;
        state_d = S_CLIP;
      end
      S_CLIP: begin
        mul_a   = OPW'(a_q);
        mul_b   = OPW'(x_q);
        mul_en  = 1'b1;
        state_d = S_ADDR;
      end
      S_ADDR: begin
        mul_a   = OPW'(b_q);
        mul_b   = OPW'(x_q);
        mul_en  = 1'b1;
        state_d = S_RD0;
      end
      S_RD0: begin
        state_d = S_RD1;
      end
      S_RD1: begin
        mem_raddr = n1_w[AW-1:0];
        state_d   = S_DIFF;
      end
      S_DIFF: begin
        state_d = S_MULF;
      end
      S_MULF: begin
        mul_a   = OPW'(diff_q);
        mul_b   = OPW'($signed({1'b0, f_q}));
        mul_en  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_MULC;
      end
      S_MULC: begin
        mul_a   = OPW'(c_q);
        mul_b   = OPW'($signed(sample_out_q));
        mul_en  = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        mem_we = 1'b1;
        if (head_q == g) begin
          state_d = S_WR0;
        end else begin
          head_d  = head_q + AW'(1);
          state_d = S_IDLE;
        end
      end
      S_WR0: begin
        // guard copy of the last ring entry
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = w_q;
        head_d    = AW'(1);
        wrapped_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // a length write empties the store
    if (cfg_ll_wr) begin
      head_d    = '0;
      wrapped_d = 1'b0;
    end
  end

  assign mul_p = (PW)'(mul_a) * (PW)'(mul_b);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      wrapped_q <= wrapped_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LINE_LENGTH_RESET;
      spm_q         <= SPM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_LENGTH:    line_length_q <= cfg_data_i[LL_W-1:0];
        REG_SAMPLES_PER_MS: spm_q         <= cfg_data_i[SPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q   <= sample_in_i;
      dly_q <= delay_ms_i;
      a_q   <= gain_direct_i;
      b_q   <= gain_feed_in_i;
      c_q   <= gain_feedback_i;
    end
    if (mul_en) begin
      p_q <= mul_p;
    end
    if (out_load) begin
      sample_out_q <= y;
    end
    case (state_q)
      S_CLIP: begin
        pres_q <= !d_full[DPROD_W-1];
        d_q    <= (d_full > gfix) ? gfix_u : d_full[AW+FRAC_W-1:0];
      end
      S_ADDR: begin
        n_q  <= r_adj[AW+FRAC_W-1:FRAC_W];
        f_q  <= r_adj[FRAC_W-1:0];
        ax_q <= $signed(p_q[SW+15:14]);
      end
      S_RD0: begin
        bx_q <= $signed(p_q[SW+15:0]);
      end
      S_RD1: begin
        v0_q <= valid0 ? $signed(mem_rdata) : '0;
      end
      S_DIFF: begin
        diff_q <= (SW + 1)'(v1) - (SW + 1)'(v0_q);
      end
      S_WR: begin
        w_q <= w;
      end
      default: ;
    endcase
  end

  // Delay store
  icf_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  // Checks
  `ICF_ASSERT_NEVER(a_head_in_ring, head_q > g, "write head beyond ring period")
  `ICF_ASSERT(a_start_after_xfer, in_xfer |=> state_q == S_MULD, "item transfer did not start")
  `ICF_ASSERT(a_valid_from_out, $rose(out_valid_q) |-> $past(state_q) == S_OUT, "result without out step")
  `ICF_ASSERT(a_guard_at_wrap, state_q == S_WR0 |-> head_q == g, "guard write away from wrap")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the interpolated comb filter: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
  import icf_pkg::*;

  localparam int     SW          = SAMPLE_WIDTH_DEFAULT;
  localparam int     DEPTH_N     = DEPTH_DEFAULT;
  localparam int     GAIN_FRAC   = 14;
  localparam longint UNIT        = longint'(1) << FRAC_W;  // one sample of delay
  localparam longint SAMPLE_MAX  = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
  localparam int     DLY_MAX     = (1 << (DLY_W - 1)) - 1;
  localparam int     NUM_PHASES  = 10;
  localparam int     PHASE_ITEMS = 40;
  localparam int     HOLD_CYCLES = 200;
  localparam int     SETTLE      = 16;
  localparam int     CYCLE_LIMIT = 300000;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic signed [SW-1:0]     sample;
    logic signed [DLY_W-1:0]  delay;
    logic signed [GAIN_W-1:0] g_direct;
    logic signed [GAIN_W-1:0] g_feed_in;
    logic signed [GAIN_W-1:0] g_feedback;
  } sample_item_t;

  typedef struct {
    int x;
    int dly;
    int a;
    int b;
    int c;
    bit typed;
    int want;
  } directed_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [SW-1:0]     sample_in_i;
  logic signed [DLY_W-1:0]  delay_ms_i;
  logic signed [GAIN_W-1:0] gain_direct_i;
  logic signed [GAIN_W-1:0] gain_feed_in_i;
  logic signed [GAIN_W-1:0] gain_feedback_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [SW-1:0]     sample_out_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  // Predictor state
  longint            delay_line [DEPTH_N];
  int                head_pos;
  logic [LL_W-1:0]   len_reg;
  logic [SPM_W-1:0]  rate_reg;

  logic signed [SW-1:0] pending_samples [$];
  int mismatch_count;
  int cycle_count;
  int idle_odds;      // 1-in-N chance of an idle burst, 0 = no idling
  int hold_reqs;      // long receiver hold-offs asked for
  int holds_served;

  // Directed rows: negative delays give y = a*x alone, so those are typed in
  directed_row_t directed_rows [16] = '{
    '{32767, -1, 16384, 16384, 0, 1'b1, 32767},
    '{-32768, -524288, -32768, 32767, -32768, 1'b1, 32767},
    '{-32768, -2, 32767, -32768, 32767, 1'b1, -32768},
    '{-1, -100, 1, 0, 0, 1'b1, -1},
    '{1, -100, 1, 0, 0, 1'b1, 0},
    '{0, -524288, 0, 0, 0, 1'b1, 0},
    '{12345, 0, 0, 16384, 0, 1'b0, 0},
    '{1000, 93, 16384, 16384, 8192, 1'b0, 0},
    '{-5000, 186, 16384, 16384, -8192, 1'b0, 0},
    '{7, 524287, 16384, 16384, 16384, 1'b0, 0},
    '{32767, 1, -16384, -32768, -32768, 1'b0, 0},
    '{-32768, 500, 32767, 32767, 32767, 1'b0, 0},
    '{20000, 46, 8000, 16384, 16384, 1'b0, 0},
    '{-20000, 280, -8000, -16384, 0, 1'b0, 0},
    '{21845, 174762, 21845, -21846, -21846, 1'b0, 0},
    '{-21846, 349525, -21846, 21845, -21846, 1'b0, 0}
  };

  interpolated_comb_filter #(
    .DEPTH       (DEPTH_N),
    .SAMPLE_WIDTH(SW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_in_i    (sample_in_i),
    .delay_ms_i     (delay_ms_i),
    .gain_direct_i  (gain_direct_i),
    .gain_feed_in_i (gain_feed_in_i),
    .gain_feedback_i(gain_feedback_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Ring length in use, clamped to 2..DEPTH
  function automatic int line_span();
    int l;
    l = int'(len_reg);
    if (l < 2) l = 2;
    if (l > DEPTH_N) l = DEPTH_N;
    return l;
  endfunction

  function automatic logic signed [SW-1:0] clamp_sample(input longint v);
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return SW'(v);
  endfunction

  // Computes y for one sample and advances the delay line
  function automatic logic signed [SW-1:0] filter_sample(input sample_item_t it);
    longint x, ga, gb, gc, gfix, acc, d, r, v0, v1, frac, term;
    logic signed [SW-1:0] y, w;
    int g, h, n, n1;
    x    = longint'(it.sample);
    ga   = longint'(it.g_direct);
    gb   = longint'(it.g_feed_in);
    gc   = longint'(it.g_feedback);
    g    = line_span() - 1;
    gfix = longint'(g) * UNIT;
    acc  = ga * x;
    d    = longint'(it.delay) * longint'(rate_reg);
    h    = head_pos;
    if (h > g) h = 0;
    // interpolated tap behind the write head
    if (d >= 0) begin
      if (d > gfix) d = gfix;
      r = longint'(h) * UNIT - d;
      if (r < 0) r += gfix;
      n = int'(r >>> FRAC_W);
      if (n > g) n = g;
      n1 = (n + 1 < DEPTH_N) ? n + 1 : n;
      v0 = delay_line[n];
      v1 = delay_line[n1];
      frac = r & (UNIT - 1);
      term = v0 + (((v1 - v0) * frac) >>> FRAC_W);
      acc += term * (longint'(1) << GAIN_FRAC);
    end
    y = clamp_sample(acc >>> GAIN_FRAC);
    w = clamp_sample((gb * x + gc * longint'(y)) >>> GAIN_FRAC);
    // write back, with guard copy at the wrap
    if (h == g) begin
      delay_line[g] = longint'(w);
      delay_line[0] = longint'(w);
      head_pos = 1;
    end else begin
      delay_line[h] = longint'(w);
      head_pos = h + 1;
    end
    return y;
  endfunction

  function automatic logic signed [GAIN_W-1:0] rand_gain(input int span);
    if ($urandom_range(0, 7) == 0) return GAIN_W'($urandom);
    return GAIN_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random item, mostly with delays that land inside the current ring
  function automatic sample_item_t rand_item();
    sample_item_t it;
    longint v, tgt;
    case ($urandom_range(0, 9))
      0:       it.sample = SW'(SAMPLE_MAX);
      1:       it.sample = SW'(SAMPLE_MIN);
      default: it.sample = SW'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: v = -longint'($urandom_range(1, DLY_MAX + 1));
      1: v = longint'($urandom_range(0, 2 * DLY_MAX + 1)) - DLY_MAX - 1;
      default: begin
        tgt = (longint'($urandom_range(0, line_span() - 1)) << FRAC_W)
            + longint'($urandom_range(0, (1 << FRAC_W) - 1));
        if (rate_reg == '0) v = longint'($urandom_range(0, DLY_MAX));
        else v = tgt / longint'(rate_reg);
        if (v > DLY_MAX) v = DLY_MAX;
      end
    endcase
    it.delay      = DLY_W'(v);
    it.g_direct   = rand_gain(16384);
    it.g_feed_in  = rand_gain(16384);
    it.g_feedback = rand_gain(12000);
    return it;
  endfunction

  // Register write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_LINE_LENGTH) begin
      len_reg  = data[LL_W-1:0];
      head_pos = 0;
      foreach (delay_line[i]) delay_line[i] = 0;
    end else if (idx == REG_SAMPLES_PER_MS) begin
      rate_reg = data[SPM_W-1:0];
    end
  endtask

  // Offer one sample; on transfer record the expected output
  task automatic offer(input sample_item_t it, input bit typed, input logic signed [SW-1:0] want);
    logic signed [SW-1:0] y;
    @(negedge clk_i);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    sample_in_i     = it.sample;
    delay_ms_i      = it.delay;
    gain_direct_i   = it.g_direct;
    gain_feed_in_i  = it.g_feed_in;
    gain_feedback_i = it.g_feedback;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    y = filter_sample(it);
    pending_samples.push_back(typed ? want : y);
  endtask

  // Stop offering and wait for all outputs, then let the write-back finish
  task automatic drain(input int extra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Output checker
  initial mismatch_count = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        $error("sample_out: no transfer pending, got %0d", sample_out_o);
        mismatch_count++;
      end else begin
        logic signed [SW-1:0] want;
        want = pending_samples.pop_front();
        if (sample_out_o !== want) begin
          $error("sample_out: expected %0d, got %0d", want, sample_out_o);
          mismatch_count++;
        end
      end
    end
  end

  // Output side: random stall bursts plus requested long hold-offs
  initial begin
    int stall_left;
    stall_left   = 0;
    holds_served = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_served) begin
        holds_served++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Main sequence
  initial begin
    sample_item_t it;
    int len, rate;
    hold_reqs       = 0;
    idle_odds       = 4;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sample_in_i     = '0;
    delay_ms_i      = '0;
    gain_direct_i   = '0;
    gain_feed_in_i  = '0;
    gain_feedback_i = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    len_reg         = LINE_LENGTH_RESET;
    rate_reg        = SPM_RESET;
    head_pos        = 0;
    foreach (delay_line[i]) delay_line[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table at reset settings
    foreach (directed_rows[i]) begin
      it.sample     = SW'(directed_rows[i].x);
      it.delay      = DLY_W'(directed_rows[i].dly);
      it.g_direct   = GAIN_W'(directed_rows[i].a);
      it.g_feed_in  = GAIN_W'(directed_rows[i].b);
      it.g_feedback = GAIN_W'(directed_rows[i].c);
      offer(it, directed_rows[i].typed, SW'(directed_rows[i].want));
    end

    // Random phases over several register settings, -1 means random
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin len = 2;    rate = 1;     end
        1:       begin len = 0;    rate = 0;     end  // both below range: zero rate
        2:       begin len = 1;    rate = 256;   end
        3:       begin len = 512;  rate = 65535; end
        4:       begin len = 1023; rate = 2822;  end
        5:       begin len = 5;    rate = 4096;  end
        6:       begin len = 17;   rate = 11290; end
        7:       begin len = 300;  rate = -1;    end
        8:       begin len = -1;   rate = -1;    end
        default: begin len = 441;  rate = 11290; end
      endcase
      if (len < 0) len = int'($urandom_range(0, (1 << LL_W) - 1));
      if (rate < 0) rate = int'($urandom_range(1, (1 << SPM_W) - 1));
      idle_odds = (p == NUM_PHASES - 1 || p % 4 == 1) ? 0 : 4;
      drain(SETTLE);
      // upper data bits above the length field are junk on purpose
      write_reg(REG_LINE_LENGTH,
                CFG_DATA_W'(len) | (CFG_DATA_W'($urandom_range(0, 63)) << LL_W));
      write_reg(REG_SAMPLES_PER_MS, CFG_DATA_W'(rate));
      if (p == 3) begin
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 10) hold_reqs++;   // output held off while input keeps coming
        if (p == 4 && k == 20) drain(0);      // input pauses until all outputs are back
        offer(rand_item(), 1'b0, '0);
      end
    end

    drain(SETTLE);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
